@@ rtl/bps_pkg.sv @@
// ============================================================================
// bps_pkg: shared types and constants of the beep pattern sequencer
// Step table geometry, field widths and transaction command codes.
// ============================================================================
package bps_pkg;

    // Step table depth
    localparam int MAX_STEPS = 10;

    // Fixed payload widths
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 4;
    localparam int FREQ_W  = 16;
    localparam int TICKS_W = 16;
    localparam int LEN_W   = 4;

    // Table address, step index and length widths derived from the depth
    localparam int ADDR_W  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int STEP_W  = $clog2(MAX_STEPS + 1);
    // Common width for comparing slots and lengths against MAX_STEPS
    localparam int CMP_W   = 8;

    // One table entry: frequency in the upper half, duration in the lower
    localparam int ENTRY_W = FREQ_W + TICKS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_START = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [FREQ_W-1:0]  freq;
        logic [TICKS_W-1:0] ticks;
    } entry_t;

endpackage

@@ rtl/bps_in_if.sv @@
// ============================================================================
// bps_in_if: command channel of the beep pattern sequencer
// Valid/ready channel carrying one command transaction.
// ============================================================================
interface bps_in_if;
    logic                           valid;
    logic                           ready;
    logic [bps_pkg::CMD_W-1:0]      cmd;
    logic [bps_pkg::SLOT_W-1:0]     step_slot;
    logic [bps_pkg::FREQ_W-1:0]     step_freq;
    logic [bps_pkg::TICKS_W-1:0]    step_ticks;
    logic [bps_pkg::LEN_W-1:0]      pattern_length;

    modport source (
        output valid, cmd, step_slot, step_freq, step_ticks, pattern_length,
        input  ready
    );
    modport sink (
        input  valid, cmd, step_slot, step_freq, step_ticks, pattern_length,
        output ready
    );
endinterface

@@ rtl/bps_out_if.sv @@
// ============================================================================
// bps_out_if: result channel of the beep pattern sequencer
// Valid/ready channel carrying one tone status transaction.
// ============================================================================
interface bps_out_if;
    logic                           valid;
    logic                           ready;
    logic [bps_pkg::FREQ_W-1:0]     tone_freq;
    logic                           playing;
    logic                           changed;

    modport source (
        output valid, tone_freq, playing, changed,
        input  ready
    );
    modport sink (
        input  valid, tone_freq, playing, changed,
        output ready
    );
endinterface

@@ rtl/bps_ram.sv @@
// ============================================================================
// bps_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data registered, held without read.
// ============================================================================
module bps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/beep_pattern_sequencer_top.sv @@
// ============================================================================
// beep_pattern_sequencer_top: tone pattern sequencer
// Step table in RAM, read-modify pipeline updating the playback state.
// ============================================================================
//
//  Channel | Dir | Handshake   | Payload
//  --------+-----+-------------+------------------------------------------------
//  req     | in  | valid/ready | cmd, step_slot, step_freq, step_ticks,
//          |     |             | pattern_length
//  rsp     | out | valid/ready | tone_freq, playing, changed
//
//  One transaction per cycle sustained while rsp.ready stays high. Each result
//  passes the execute stage, whose table read is issued at acceptance, then the
//  result register. The RAM read port sets the latency: the entry a command
//  may load is read at acceptance, and the playback state is updated when the
//  command leaves the execute stage. Reset clears the playback state and the
//  pipeline valid flags; the table contents are undefined until written.
//  A stalled result holds the execute stage, and req.ready drops if it is full.
//
module beep_pattern_sequencer_top (
    input  logic       clk,
    input  logic       rst_n,
    bps_in_if.sink     req,
    bps_out_if.source  rsp
);

    localparam int STEP_W  = bps_pkg::STEP_W;
    localparam int ADDR_W  = bps_pkg::ADDR_W;
    localparam int CMP_W   = bps_pkg::CMP_W;
    localparam int FREQ_W  = bps_pkg::FREQ_W;
    localparam int TICKS_W = bps_pkg::TICKS_W;

    // ------------------------------------------------------------------------
    // Playback state
    // ------------------------------------------------------------------------
    logic [STEP_W-1:0]  length_reg,  length_next;
    logic [STEP_W-1:0]  step_reg,    step_next;
    logic [TICKS_W-1:0] ticks_reg,   ticks_next;
    logic               running_reg, running_next;
    logic [FREQ_W-1:0]  freq_reg,    freq_next;
    logic               changed;

    // Execute stage
    logic               s1_valid_reg, s1_valid_next;
    bps_pkg::cmd_t      s1_cmd_reg;
    logic [STEP_W-1:0]  s1_len_reg;
    logic               s1_adv;
    logic               s1_fire;

    // Result register
    logic               out_valid_reg;
    logic [FREQ_W-1:0]  out_freq_reg;
    logic               out_playing_reg;
    logic               out_changed_reg;

    // Acceptance and table access
    logic               accept;
    bps_pkg::cmd_t      in_cmd;
    logic [CMP_W-1:0]   in_len_ext;
    logic [CMP_W-1:0]   in_slot_ext;
    logic [STEP_W-1:0]  in_len_sat;
    logic [STEP_W-1:0]  rd_step;
    logic               rd_in_range;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    bps_pkg::entry_t    wr_entry;
    bps_pkg::entry_t    rd_entry;
    logic [STEP_W-1:0]  adv_step;

    // ------------------------------------------------------------------------
    // Handshake: the execute stage moves on whenever the result register is
    // free or being drained; take a new command whenever the stage frees up.
    // ------------------------------------------------------------------------
    assign s1_adv    = !out_valid_reg || rsp.ready;
    assign s1_fire   = s1_valid_reg && s1_adv;
    assign req.ready = !s1_valid_reg || s1_adv;
    assign accept    = req.valid && req.ready;

    assign in_cmd      = bps_pkg::cmd_t'(req.cmd);
    assign in_len_ext  = CMP_W'(req.pattern_length);
    assign in_slot_ext = CMP_W'(req.step_slot);
    // Saturate the pattern length to the table depth
    assign in_len_sat  = (in_len_ext > CMP_W'(bps_pkg::MAX_STEPS))
                         ? STEP_W'(bps_pkg::MAX_STEPS)
                         : in_len_ext[STEP_W-1:0];

    // ------------------------------------------------------------------------
    // Execute: apply the command in the stage to the playback state. The
    // table entry it may load arrives from the RAM read issued at acceptance.
    // ------------------------------------------------------------------------
    assign adv_step = step_reg + STEP_W'(1);

    always_comb
    begin
        length_next  = length_reg;
        step_next    = step_reg;
        ticks_next   = ticks_reg;
        running_next = running_reg;
        freq_next    = freq_reg;
        changed      = 1'b0;
        if (s1_fire)
        begin
            unique case (s1_cmd_reg)
                bps_pkg::CMD_TICK:
                begin
                    if (running_reg)
                    begin
                        changed = (ticks_reg == '0);
                        if (ticks_reg != '0)
                        begin
                            // count down the current step
                            ticks_next = ticks_reg - TICKS_W'(1);
                        end
                        else if (adv_step >= length_reg)
                        begin
                            // past the last step: stop
                            running_next = 1'b0;
                            freq_next    = '0;
                        end
                        else
                        begin
                            // advance and load the next step
                            step_next  = adv_step;
                            freq_next  = rd_entry.freq;
                            ticks_next = rd_entry.ticks;
                        end
                    end
                end
                bps_pkg::CMD_START:
                begin
                    length_next  = s1_len_reg;
                    step_next    = '0;
                    freq_next    = rd_entry.freq;
                    ticks_next   = rd_entry.ticks;
                    running_next = 1'b1;
                    changed      = 1'b1;
                end
                bps_pkg::CMD_WRITE,
                bps_pkg::CMD_NONE:
                begin
                    changed = 1'b0;
                end
                default:
                begin
                    changed = 1'b0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Table access at acceptance. A tick may need the step after the one the
    // execute stage leaves behind; a start always needs entry 0. Writes land
    // at acceptance too, so every read sees all earlier writes in order.
    // ------------------------------------------------------------------------
    assign rd_step     = step_next + STEP_W'(1);
    assign rd_in_range = CMP_W'(rd_step) < CMP_W'(bps_pkg::MAX_STEPS);
    assign rd_addr     = (in_cmd == bps_pkg::CMD_START || !rd_in_range)
                         ? '0 : rd_step[ADDR_W-1:0];

    assign wr_en          = accept && (in_cmd == bps_pkg::CMD_WRITE)
                            && (in_slot_ext < CMP_W'(bps_pkg::MAX_STEPS));
    assign wr_addr        = in_slot_ext[ADDR_W-1:0];
    assign wr_entry.freq  = req.step_freq;
    assign wr_entry.ticks = req.step_ticks;

    bps_ram #(
        .WIDTH (bps_pkg::ENTRY_W),
        .DEPTH (bps_pkg::MAX_STEPS)
    ) u_step_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rd_entry)
    );

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            step_reg      <= '0;
            ticks_reg     <= '0;
            running_reg   <= 1'b0;
            freq_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            length_reg   <= length_next;
            step_reg     <= step_next;
            ticks_reg    <= ticks_next;
            running_reg  <= running_next;
            freq_reg     <= freq_next;
            s1_valid_reg <= s1_valid_next;
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: capture the command into execute, the result out
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= in_cmd;
            s1_len_reg <= in_len_sat;
        end
        if (s1_fire)
        begin
            out_freq_reg    <= running_next ? freq_next : '0;
            out_playing_reg <= running_next;
            out_changed_reg <= changed;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.tone_freq = out_freq_reg;
    assign rsp.playing   = out_playing_reg;
    assign rsp.changed   = out_changed_reg;

endmodule

@@ sim/bps_tone_checker.sv @@
// ============================================================================
// bps_tone_checker: scoreboard for the beep pattern sequencer
// Tracks the step table and playback state from accepted commands and
// compares every accepted tone status against the predicted one.
// ============================================================================
module bps_tone_checker (
    input  logic clk,
    input  logic rst_n,
    bps_in_if    req,
    bps_out_if   rsp,
    output int   mismatches,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import bps_pkg::*;

    typedef struct {
        logic [FREQ_W-1:0] tone;
        logic              playing;
        logic              changed;
    } tone_status_t;

    logic [FREQ_W-1:0]  freq_tab [MAX_STEPS];
    logic [TICKS_W-1:0] dur_tab  [MAX_STEPS];
    int unsigned        seq_len;
    int unsigned        step_idx;
    logic [TICKS_W-1:0] remain;
    logic               active;
    logic [FREQ_W-1:0]  cur_tone;
    tone_status_t       status_q [$];

    // Apply one command to the shadow state and return the status it produces
    function automatic tone_status_t play_command(cmd_t op, logic [SLOT_W-1:0] slot,
                                                  logic [FREQ_W-1:0] freq,
                                                  logic [TICKS_W-1:0] dur,
                                                  logic [LEN_W-1:0] len);
        tone_status_t st;
        st.changed = 1'b0;
        case (op)
            CMD_TICK:
            begin
                if (active)
                begin
                    if (remain != '0)
                        remain = remain - 1'b1;
                    else
                    begin
                        if (step_idx + 1 >= seq_len)
                        begin
                            active   = 1'b0;
                            cur_tone = '0;
                        end
                        else
                        begin
                            step_idx = step_idx + 1;
                            cur_tone = freq_tab[step_idx];
                            remain   = dur_tab[step_idx];
                        end
                        st.changed = 1'b1;
                    end
                end
            end
            CMD_WRITE:
            begin
                if (slot < MAX_STEPS)
                begin
                    freq_tab[slot] = freq;
                    dur_tab[slot]  = dur;
                end
            end
            CMD_START:
            begin
                seq_len    = (len > MAX_STEPS) ? MAX_STEPS : len;
                step_idx   = 0;
                cur_tone   = freq_tab[0];
                remain     = dur_tab[0];
                active     = 1'b1;
                st.changed = 1'b1;
            end
            default:
            begin
            end
        endcase
        st.tone    = active ? cur_tone : '0;
        st.playing = active;
        return st;
    endfunction

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tone_status_t want;
        if (!rst_n)
        begin
            active   = 1'b0;
            cur_tone = '0;
            remain   = '0;
            seq_len  = 0;
            step_idx = 0;
            status_q.delete();
        end
        else
        begin
            if (req.valid && req.ready)
                status_q.push_back(play_command(cmd_t'(req.cmd), req.step_slot, req.step_freq,
                                                req.step_ticks, req.pattern_length));
            if (rsp.valid && rsp.ready)
            begin
                if (status_q.size() == 0)
                    report_mismatch("tone status with no command pending", 0, 1);
                else
                begin
                    want = status_q.pop_front();
                    if (rsp.tone_freq !== want.tone)
                        report_mismatch("tone_freq", want.tone, rsp.tone_freq);
                    if (rsp.playing !== want.playing)
                        report_mismatch("playing", want.playing, rsp.playing);
                    if (rsp.changed !== want.changed)
                        report_mismatch("changed", want.changed, rsp.changed);
                end
            end
        end
        outstanding = status_q.size();
    end

endmodule

@@ sim/tb_beep_pattern_sequencer_top.sv @@
// ============================================================================
// tb_beep_pattern_sequencer_top: testbench of the beep pattern sequencer
// Drives directed and random command transactions with random gaps and
// result back-pressure; a separate checker predicts and compares results.
// ============================================================================
module tb_beep_pattern_sequencer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bps_pkg::*;

    logic        clk;
    logic        rst_n;
    int          fail_count;
    int          in_flight;
    // High while neither side may insert idle cycles
    bit          quiet;
    // Transactions that do real work (unused codes and bad slots excluded)
    int unsigned useful_sent;

    bps_in_if  req ();
    bps_out_if rsp ();

    beep_pattern_sequencer_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    bps_tone_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mismatches  (fail_count),
        .outstanding (in_flight)
    );

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the handshake hangs; far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result side: now and then (never while quiet) hold ready low for a random burst,
    // otherwise accept every cycle. Change only on the falling edge.
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // Slots mostly land in the table; a few fall past its end and are dropped
    function automatic logic [SLOT_W-1:0] pick_slot();
        if ($urandom_range(0, 9) == 0)
            return SLOT_W'($urandom_range(MAX_STEPS, 15));
        return SLOT_W'($urandom_range(0, MAX_STEPS - 1));
    endfunction

    // Short durations keep sequences moving; now and then a full-range one
    function automatic logic [TICKS_W-1:0] pick_dur();
        if ($urandom_range(0, 11) == 0)
            return TICKS_W'($urandom);
        return TICKS_W'($urandom_range(0, 3));
    endfunction

    // Silent steps show up often enough to matter
    function automatic logic [FREQ_W-1:0] pick_freq();
        if ($urandom_range(0, 7) == 0)
            return '0;
        return FREQ_W'($urandom);
    endfunction

    // Present one command transaction at the falling edge, optionally after
    // an idle burst, and hold it until the block takes it.
    task automatic send_cmd(cmd_t op, logic [SLOT_W-1:0] slot, logic [FREQ_W-1:0] freq,
                            logic [TICKS_W-1:0] dur, logic [LEN_W-1:0] len);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        req.valid          <= 1'b1;
        req.cmd            <= op;
        req.step_slot      <= slot;
        req.step_freq      <= freq;
        req.step_ticks     <= dur;
        req.pattern_length <= len;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if (!(op == CMD_NONE || (op == CMD_WRITE && slot >= MAX_STEPS)))
            useful_sent++;
        @(negedge clk);
    endtask

    // Tick with junk in the fields it does not use
    task automatic send_tick();
        send_cmd(CMD_TICK, SLOT_W'($urandom), FREQ_W'($urandom), TICKS_W'($urandom),
                 LEN_W'($urandom));
    endtask

    initial
    begin
        int unsigned plen;
        int unsigned n_wr;
        int unsigned n_tk;

        rst_n              = 1'b0;
        quiet              = 1'b0;
        useful_sent        = 0;
        req.valid          = 1'b0;
        req.cmd            = CMD_TICK;
        req.step_slot      = '0;
        req.step_freq      = '0;
        req.step_ticks     = '0;
        req.pattern_length = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- Directed part ---
        // Nothing playing yet: a tick and the unused code must do nothing
        send_cmd(CMD_TICK, '0, '0, '0, '0);
        send_cmd(CMD_NONE, '1, '1, '1, '1);
        // Writes past the table end are dropped
        send_cmd(CMD_WRITE, 4'd15, '1, '1, '0);
        send_cmd(CMD_WRITE, SLOT_W'(MAX_STEPS), '1, '1, '0);
        // Fill every entry so that no start or advance ever reads a stale slot
        send_cmd(CMD_WRITE, 4'd0, '1, 16'd1, '1);
        send_cmd(CMD_WRITE, 4'd1, '0, '0, '1);
        send_cmd(CMD_WRITE, 4'd2, 16'd1, '1, '1);
        for (int s = 3; s < MAX_STEPS; s++)
            send_cmd(CMD_WRITE, SLOT_W'(s), FREQ_W'(100 * s), TICKS_W'(s % 3), '1);
        // Zero length still plays step 0; the tick that finds zero stops it
        send_cmd(CMD_START, '1, '1, '1, '0);
        send_tick();
        send_tick();
        // Length above the table depth saturates
        send_cmd(CMD_START, '0, '0, '0, '1);
        // Rewrite a step before it is reached; the new value must load
        send_cmd(CMD_WRITE, 4'd1, 16'h1234, '0, '0);
        send_tick();
        send_tick();
        send_tick();
        // Now on the longest step; unused code changes nothing mid-play
        send_tick();
        send_cmd(CMD_NONE, '0, '0, '0, '0);
        // Restart mid-sequence with one step, then run it out
        send_cmd(CMD_START, '0, '0, '0, 4'd1);
        send_tick();
        send_tick();

        // --- Random part ---
        // Each round writes a few steps, starts a sequence and ticks it along,
        // with stray writes, unused codes and early restarts mixed in.
        while (useful_sent < 1550)
        begin
            if (useful_sent >= 1350)
                quiet = 1'b1;
            else
                quiet = ($urandom_range(0, 3) == 0);

            n_wr = $urandom_range(0, 4);
            repeat (n_wr)
                send_cmd(CMD_WRITE, pick_slot(), pick_freq(), pick_dur(), LEN_W'($urandom));
            if ($urandom_range(0, 7) == 0)
                send_cmd(CMD_NONE, SLOT_W'($urandom), FREQ_W'($urandom),
                         TICKS_W'($urandom), LEN_W'($urandom));
            if ($urandom_range(0, 9) == 0)
                send_tick();

            if ($urandom_range(0, 9) == 0)
                plen = $urandom_range(MAX_STEPS + 1, 15);
            else
                plen = $urandom_range(0, MAX_STEPS);
            send_cmd(CMD_START, SLOT_W'($urandom), FREQ_W'($urandom), TICKS_W'($urandom),
                     LEN_W'(plen));

            n_tk = $urandom_range(0, 4 * plen + 6);
            repeat (n_tk)
            begin
                case ($urandom_range(0, 15))
                    0:
                        send_cmd(CMD_WRITE, pick_slot(), pick_freq(), pick_dur(),
                                 LEN_W'($urandom));
                    1:
                        send_cmd(CMD_NONE, SLOT_W'($urandom), FREQ_W'($urandom),
                                 TICKS_W'($urandom), LEN_W'($urandom));
                    default:
                        send_tick();
                endcase
            end
        end

        // Drain: drop valid, wait for every result, then a few more cycles
        quiet = 1'b1;
        req.valid <= 1'b0;
        wait (in_flight == 0);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
